### hdl/mbe_pkg.sv
package mbe_pkg;

  // Image bounds; an index at or beyond them is clamped to the last column or row
  localparam int MaxColumns = 4096;
  localparam int MaxRows    = 4096;

  // Depth of the job queue between front and back
  localparam int QueueDepth = 2;

  // Configuration register indexes
  localparam logic [2:0] RegXOrigin   = 3'd0;
  localparam logic [2:0] RegYOrigin   = 3'd1;
  localparam logic [2:0] RegXStep     = 3'd2;
  localparam logic [2:0] RegYStep     = 3'd3;
  localparam logic [2:0] RegIterLimit = 3'd4;
  localparam logic [2:0] RegEscLimit  = 3'd5;
  localparam logic [2:0] RegColor     = 3'd6;

  // Input word: one pixel
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pix_in_t;

  // Output word: one result
  typedef struct packed {
    logic [15:0] iteration_count;
    logic        inside_set;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pix_out_t;

  // Configuration register file
  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        iteration_limit;
    logic [31:0]        escape_limit_sq;
    logic [23:0]        escape_color;
  } cfg_t;

  // Mapped point handed from front to back
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } job_t;

  // Queue handshake toward either side
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/mbe_front.sv
module mbe_front import mbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      start_i,
  input  pix_in_t   pixel_i,
  output logic      busy_o,
  input  q_status_t q_status_i,
  output logic      push_o,
  output job_t      job_o
);

  localparam logic [1:0] FIdle = 2'd0;
  localparam logic [1:0] FMulX = 2'd1;
  localparam logic [1:0] FMulY = 2'd2;
  localparam logic [1:0] FPush = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [11:0]        col_q, col_d, row_q, row_d;
  logic [42:0]        prod_q, prod_d;
  logic signed [31:0] cx_q, cx_d;
  logic [11:0]        mul_a;
  logic [30:0]        mul_b;
  logic signed [44:0] cxw, cyw;
  logic [45:0]        cy_mag;
  logic               snap;
  logic signed [31:0] cy_sat;

  // Clamp indexes beyond the image
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (state_q == FIdle) begin
      col_d = (32'(pixel_i.column) >= 32'(MaxColumns)) ? 12'(MaxColumns - 1) : pixel_i.column;
      row_d = (32'(pixel_i.row) >= 32'(MaxRows)) ? 12'(MaxRows - 1) : pixel_i.row;
    end
  end

  // Share one index-times-step multiplier between the two axes
  assign mul_a  = (state_q == FMulX) ? col_q : row_q;
  assign mul_b  = (state_q == FMulX) ? cfg_i.x_step : cfg_i.y_step;
  assign prod_d = 43'(mul_a) * 43'(mul_b);

  // Form both coordinates at full width
  assign cxw = $signed({2'b00, prod_q}) + 45'(cfg_i.x_origin);
  assign cyw = $signed({2'b00, prod_q}) + 45'(cfg_i.y_origin);

  // Snap the imaginary part to zero when within half a row step
  assign cy_mag = cyw[44] ? 46'(-cyw) : 46'(cyw);
  assign snap   = {cy_mag, 1'b0} < 47'(cfg_i.y_step);

  // Saturate to 32 bit signed
  always_comb begin
    if ((cxw[44:31] == '0) || (cxw[44:31] == '1)) begin
      cx_d = cxw[31:0];
    end else begin
      cx_d = cxw[44] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if (snap) begin
      cy_sat = '0;
    end else if ((cyw[44:31] == '0) || (cyw[44:31] == '1)) begin
      cy_sat = cyw[31:0];
    end else begin
      cy_sat = cyw[44] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // Sequence: accept, multiply column, multiply row, push
  always_comb begin
    state_d = state_q;
    case (state_q)
      FIdle: if (start_i) state_d = FMulX;
      FMulX: state_d = FMulY;
      FMulY: state_d = FPush;
      FPush: if (!q_status_i.full) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers: hold the product while waiting for queue space
  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
    if (state_q == FMulX || state_q == FMulY) prod_q <= prod_d;
    if (state_q == FMulY) cx_q <= cx_d;
  end

  assign busy_o   = (state_q != FIdle);
  assign push_o   = (state_q == FPush) && !q_status_i.full;
  assign job_o.cx = cx_q;
  assign job_o.cy = cy_sat;

endmodule

### hdl/mbe_queue.sv
module mbe_queue import mbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign job_o          = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

### hdl/mbe_core.sv
module mbe_core import mbe_pkg::*; #(
  parameter int FRACTION_BITS = 28
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     job_valid_i,
  input  job_t     job_i,
  output logic     pop_o,
  output logic     done_o,
  output pix_out_t result_o
);

  // Widths of squares, cross product and sums
  localparam int SQW = 63 - FRACTION_BITS;
  localparam int PXW = 65 - FRACTION_BITS;
  localparam int XW  = ((SQW + 1 > 32) ? SQW + 1 : 32) + 1;
  localparam int YW  = ((PXW > 32) ? PXW : 32) + 1;
  localparam int CW  = (SQW + 1 > 32) ? SQW + 1 : 32;

  localparam logic [1:0] CIdle = 2'd0;
  localparam logic [1:0] CUpd  = 2'd1;
  localparam logic [1:0] CSq   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic signed [31:0]   cx_q, cy_q, zx_q, zy_q;
  logic [SQW-1:0]       zx2_q, zy2_q;
  logic signed [PXW-1:0] pxy_q;
  logic [15:0]          it_q;
  logic                 done_q;
  pix_out_t             result_q;

  logic signed [63:0]   sq_x, sq_y, prod_xy;
  logic [CW-1:0]        mag_sq;
  logic                 cont;
  logic signed [XW-1:0] nzx_w;
  logic signed [YW-1:0] nzy_w;
  logic signed [31:0]   nzx, nzy;
  logic                 in_set;

  // Products of the current z
  assign sq_x    = 64'(zx_q) * 64'(zx_q);
  assign sq_y    = 64'(zy_q) * 64'(zy_q);
  assign prod_xy = 64'(zx_q) * 64'(zy_q);

  // Escape and limit test
  assign mag_sq = CW'(zx2_q) + CW'(zy2_q);
  assign cont   = (it_q < cfg_i.iteration_limit) && (mag_sq < CW'(cfg_i.escape_limit_sq));

  // Next z at full width, then saturate
  assign nzx_w = XW'($signed({1'b0, zx2_q})) - XW'($signed({1'b0, zy2_q})) + XW'(cx_q);
  assign nzy_w = YW'(pxy_q) + YW'(cy_q);

  always_comb begin
    if ((nzx_w[XW-1:31] == '0) || (nzx_w[XW-1:31] == '1)) begin
      nzx = nzx_w[31:0];
    end else begin
      nzx = nzx_w[XW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if ((nzy_w[YW-1:31] == '0) || (nzy_w[YW-1:31] == '1)) begin
      nzy = nzy_w[31:0];
    end else begin
      nzy = nzy_w[YW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign in_set = (it_q == cfg_i.iteration_limit);

  // Sequence: load a job, then alternate update and squaring
  always_comb begin
    state_d = state_q;
    case (state_q)
      CIdle: if (job_valid_i) state_d = CUpd;
      CUpd:  state_d = cont ? CSq : CIdle;
      CSq:   state_d = CUpd;
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CUpd) && !cont;
    end
  end

  // Iteration datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      CIdle: begin
        cx_q  <= job_i.cx;
        cy_q  <= job_i.cy;
        zx_q  <= '0;
        zy_q  <= '0;
        zx2_q <= '0;
        zy2_q <= '0;
        pxy_q <= '0;
        it_q  <= '0;
      end
      CUpd: begin
        if (cont) begin
          zx_q <= nzx;
          zy_q <= nzy;
          it_q <= it_q + 16'd1;
        end else begin
          result_q.iteration_count <= it_q;
          result_q.inside_set      <= in_set;
          result_q.red             <= in_set ? 8'h00 : cfg_i.escape_color[23:16];
          result_q.green           <= in_set ? 8'h00 : cfg_i.escape_color[15:8];
          result_q.blue            <= in_set ? 8'h00 : cfg_i.escape_color[7:0];
        end
      end
      CSq: begin
        zx2_q <= SQW'(sq_x >>> FRACTION_BITS);
        zy2_q <= SQW'(sq_y >>> FRACTION_BITS);
        pxy_q <= PXW'(prod_xy >>> (FRACTION_BITS - 1));
      end
      default: begin
        it_q <= it_q;
      end
    endcase
  end

  assign pop_o    = (state_q == CIdle) && job_valid_i;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### hdl/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time pixel engine. Raise start for one cycle with a pixel
// word while busy is low; the front maps it to a point (multiply column,
// multiply row, push) and queues it (two points may wait), so busy stays
// high through those steps and longer while the queue is full. The back
// runs z = z*z + c with three 32x32 multipliers: one state squares z and
// another updates it, and that loop sets the sustained rate; the back takes no
// new point until the current one is done. Each result word sits on
// result_o for exactly one cycle with done_o high; the receiver cannot
// stall it, so it must take every word as it comes. Results leave in input
// order. Write configuration only while no pixel is in flight.
module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
  parameter int FRACTION_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  pix_in_t     pixel_i,
  output logic        busy,
  output logic        done_o,
  output pix_out_t    result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t      cfg_q;
  q_status_t q_status;
  logic      push, pop;
  job_t      front_job, queue_job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin        <= -32'sd671088640;
      cfg_q.y_origin        <= -32'sd536870912;
      cfg_q.x_step          <= 31'd268435;
      cfg_q.y_step          <= 31'd268435;
      cfg_q.iteration_limit <= 16'd200;
      cfg_q.escape_limit_sq <= 32'd1073741824;
      cfg_q.escape_color    <= 24'hFFFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegXOrigin:   cfg_q.x_origin        <= cfg_data_i;
        RegYOrigin:   cfg_q.y_origin        <= cfg_data_i;
        RegXStep:     cfg_q.x_step          <= cfg_data_i[30:0];
        RegYStep:     cfg_q.y_step          <= cfg_data_i[30:0];
        RegIterLimit: cfg_q.iteration_limit <= cfg_data_i[15:0];
        RegEscLimit:  cfg_q.escape_limit_sq <= cfg_data_i;
        RegColor:     cfg_q.escape_color    <= cfg_data_i[23:0];
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .pixel_i    (pixel_i),
    .busy_o     (busy),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (front_job)
  );

  mbe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (front_job),
    .pop_i    (pop),
    .job_o    (queue_job),
    .status_o (q_status)
  );

  mbe_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_status.empty),
    .job_i       (queue_job),
    .pop_o       (pop),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // Result strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // Inside points are black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.inside_set) |->
      (result_o.red == 8'h00 && result_o.green == 8'h00 && result_o.blue == 8'h00))
    else $error("inside point not black");

  // Count never exceeds the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.iteration_count <= cfg_q.iteration_limit))
    else $error("iteration count beyond limit");

  // An accepted word makes the front busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("front not busy after accept");

  // The queue never pops while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

### test/mbe_checker.sv
module mbe_checker import mbe_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  pix_in_t     pixel_i,
  input  logic        busy_i,
  input  logic        done_i,
  input  pix_out_t    result_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o,
  output int          inside_o
);

  localparam longint Int32Max = 2147483647;
  localparam longint Int32Min = -Int32Max - 1;

  // Shadow copy of the register file
  logic signed [31:0] x_org;
  logic signed [31:0] y_org;
  logic [30:0]        x_stp;
  logic [30:0]        y_stp;
  logic [15:0]        iter_cap;
  logic [31:0]        esc_sq;
  logic [23:0]        color;

  // Predicted result words, oldest first
  pix_out_t awaited_pixels[$];
  int       failures;
  int       checked;
  int       inside_cnt;

  function automatic longint clip32(longint v);
    if (v > Int32Max) return Int32Max;
    if (v < Int32Min) return Int32Min;
    return v;
  endfunction

  // Map the pixel to c and run the escape-time loop
  function automatic pix_out_t escape_time(pix_in_t p);
    longint      col, row, xo, yo, xs, ys, esc;
    longint      cxw, cyw, mag, cx, cy, zx, zy, zx2, zy2, nzx;
    int unsigned iters;
    pix_out_t    r;
    col = longint'(p.column);
    row = longint'(p.row);
    xo  = longint'(x_org);
    yo  = longint'(y_org);
    xs  = longint'(x_stp);
    ys  = longint'(y_stp);
    esc = longint'(esc_sq);
    // Clamp indexes that fall beyond the image
    if (col >= MaxColumns) col = MaxColumns - 1;
    if (row >= MaxRows) row = MaxRows - 1;
    cxw = xo + col * xs;
    cyw = yo + row * ys;
    // Snap the imaginary part onto the real axis when within half a row step
    mag = (cyw < 0) ? -cyw : cyw;
    if (2 * mag < ys) cyw = 0;
    cx = clip32(cxw);
    cy = clip32(cyw);
    zx = 0;
    zy = 0;
    zx2 = 0;
    zy2 = 0;
    iters = 0;
    while (iters < iter_cap && zx2 + zy2 < esc) begin
      nzx = clip32(zx2 - zy2 + cx);
      zy  = clip32(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
      zx  = nzx;
      zx2 = (zx * zx) >>> FRAC_BITS;
      zy2 = (zy * zy) >>> FRAC_BITS;
      iters++;
    end
    r.iteration_count = iters[15:0];
    r.inside_set      = (iters == iter_cap);
    r.red             = r.inside_set ? 8'h00 : color[23:16];
    r.green           = r.inside_set ? 8'h00 : color[15:8];
    r.blue            = r.inside_set ? 8'h00 : color[7:0];
    return r;
  endfunction

  function automatic string describe(pix_out_t w);
    return $sformatf("count=%0d inside=%0b rgb=%02h_%02h_%02h",
                     w.iteration_count, w.inside_set, w.red, w.green, w.blue);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      x_org      = 32'hD800_0000;  // -2.5
      y_org      = 32'hE000_0000;  // -2.0
      x_stp      = 31'd268435;     // about 0.001
      y_stp      = 31'd268435;
      iter_cap   = 16'd200;
      esc_sq     = 32'h4000_0000;  // 4.0
      color      = 24'hFF_FFFF;
      failures   = 0;
      checked    = 0;
      inside_cnt = 0;
      awaited_pixels.delete();
    end else begin
      // Follow register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegXOrigin:   x_org    = cfg_data_i;
          RegYOrigin:   y_org    = cfg_data_i;
          RegXStep:     x_stp    = cfg_data_i[30:0];
          RegYStep:     y_stp    = cfg_data_i[30:0];
          RegIterLimit: iter_cap = cfg_data_i[15:0];
          RegEscLimit:  esc_sq   = cfg_data_i;
          RegColor:     color    = cfg_data_i[23:0];
          default: ;
        endcase
      end
      // Predict every accepted pixel word
      if (start_i && !busy_i) awaited_pixels.push_back(escape_time(pixel_i));
      // Compare each result word with the oldest prediction
      if (done_i) begin
        if (awaited_pixels.size() == 0) begin
          failures++;
          $display("%0t: mbe_chk: unexpected result word, expected none, got %s",
                   $time, describe(result_i));
        end else begin
          want = awaited_pixels.pop_front();
          if (result_i !== want) begin
            failures++;
            $display("%0t: mbe_chk: pixel %0d mismatch, expected %s, got %s",
                     $time, checked, describe(want), describe(result_i));
          end
          if (want.inside_set) inside_cnt++;
          checked++;
        end
      end
    end
    pending_o    <= awaited_pixels.size();
    fail_count_o <= failures;
    checked_o    <= checked;
    inside_o     <= inside_cnt;
  end

endmodule

### test/tb.sv
module tb;
  import mbe_pkg::*;

  localparam int          FracBits       = 28;
  localparam logic [2:0]  RegUnused      = 3'd7;
  localparam int          RandomPhases   = 42;
  localparam int          PixelsPerPhase = 45;
  localparam int          CalmPhases     = 4;
  localparam int          DrainCycles    = 16;
  localparam logic [31:0] XOriginReset   = 32'hD800_0000;  // -2.5
  localparam logic [31:0] YOriginReset   = 32'hE000_0000;  // -2.0
  localparam logic [31:0] StepReset      = 32'd268435;     // about 0.001
  localparam logic [31:0] EscReset       = 32'h4000_0000;  // 4.0

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  pix_in_t     pixel_i    = '0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = '0;
  logic [31:0] cfg_data_i = '0;
  logic        busy;
  logic        done_o;
  pix_out_t    result_o;

  int          pending;
  int          fail_count;
  int          checked;
  int          inside_count;
  logic [31:0] reg_vals [7];
  longint      cycle_count  = 0;
  longint      cycle_budget = 0;
  int          pixels_sent  = 0;
  int          settings     = 1;

  always #5 clk_i = ~clk_i;

  mandelbrot_escape_time_pixel #(.FRACTION_BITS(FracBits)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .pixel_i    (pixel_i),
    .busy       (busy),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mbe_checker #(.FRAC_BITS(FracBits)) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .pixel_i      (pixel_i),
    .busy_i       (busy),
    .done_i       (done_o),
    .result_i     (result_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked),
    .inside_o     (inside_count)
  );

  // Abort when the run overstays its cycle allowance
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_budget + 200000) begin
      $display("tb: timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Offer one pixel word and hold it until the block takes it
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    cycle_budget += 2 * longint'(reg_vals[RegIterLimit][15:0]) + 40;
    start   <= 1'b1;
    pixel_i <= {col, row};
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait until every predicted word has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Load a full register setting once the block is idle
  task automatic program_regs(input logic [31:0] xo, input logic [31:0] yo,
                              input logic [31:0] xs, input logic [31:0] ys,
                              input logic [31:0] lim, input logic [31:0] esc,
                              input logic [31:0] col, input bit poke_unused);
    reg_vals[RegXOrigin]   = xo;
    reg_vals[RegYOrigin]   = yo;
    reg_vals[RegXStep]     = xs;
    reg_vals[RegYStep]     = ys;
    reg_vals[RegIterLimit] = lim;
    reg_vals[RegEscLimit]  = esc;
    reg_vals[RegColor]     = col;
    drain();
    if (poke_unused) write_reg(RegUnused, $urandom);
    for (int i = 0; i < $size(reg_vals); i++) write_reg(3'(i), reg_vals[i]);
    cfg_we_i <= 1'b0;
    settings++;
    cycle_budget += 64;
  endtask

  initial begin
    int          kind;
    bit          calm;
    bit          gappy;
    longint      yo;
    longint      ys;
    longint      near_row;
    logic [11:0] col;
    logic [11:0] row;

    reg_vals[RegXOrigin]   = XOriginReset;
    reg_vals[RegYOrigin]   = YOriginReset;
    reg_vals[RegXStep]     = StepReset;
    reg_vals[RegYStep]     = StepReset;
    reg_vals[RegIterLimit] = 32'd200;
    reg_vals[RegEscLimit]  = EscReset;
    reg_vals[RegColor]     = 32'h00FF_FFFF;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: corners, points inside the set, rows around the real axis
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2000, 12'd2000);
    send_pixel(12'd2500, 12'd2000);
    send_pixel(12'd2000, 12'd2001);
    send_pixel(12'd2000, 12'd1999);

    // Zero escape limit: nothing iterates, the point counts as escaped
    program_regs(XOriginReset, YOriginReset, StepReset, StepReset, 200, 0,
                 32'h00FF_FFFF, 1'b0);
    send_pixel(12'd2000, 12'd2000);
    send_pixel(12'd0, 12'd0);

    // Zero iteration limit: nothing iterates, the point is inside; poke index 7
    program_regs(XOriginReset, YOriginReset, StepReset, StepReset, 0, EscReset,
                 32'h00FF_FFFF, 1'b1);
    send_pixel(12'd2000, 12'd2000);
    send_pixel(12'd4095, 12'd0);

    // Extreme origins and steps: c saturates
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 8,
                 32'hFFFF_FFFF, 32'h00A5_C30F, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'hFFFF, 32'd1,
                 32'd0, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // z runs past the 32-bit range in both directions
    program_regs(32'd0, 32'd0, 32'h2800_0000, 32'h3000_0000, 16, 32'hFFFF_FFFF,
                 32'h0012_3456, 1'b0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd1, 12'd1);

    // Row offset exactly half a step from the axis, near the cusp
    program_regs(32'h0400_0000 + 32'd200000, -32'sd500, StepReset, 32'd1000, 200, EscReset,
                 32'h00FF_FFFF, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);

    // Largest iteration limit
    program_regs(XOriginReset, YOriginReset, StepReset, StepReset, 32'hFFFF, EscReset,
                 32'h00FF_FFFF, 1'b0);
    send_pixel(12'd2000, 12'd2000);
    send_pixel(12'd0, 12'd0);

    // Random settings, mostly windows onto the set with short limits
    for (int ph = 0; ph < RandomPhases; ph++) begin
      kind  = $urandom_range(0, 9);
      calm  = (ph >= RandomPhases - CalmPhases);
      gappy = !calm && ($urandom_range(0, 2) != 0);
      if (kind == 0) begin
        program_regs($urandom, $urandom, $urandom, $urandom,
                     {16'($urandom), 16'($urandom_range(0, 48))}, $urandom, $urandom,
                     $urandom_range(0, 3) == 0);
      end else begin
        program_regs(XOriginReset + $urandom_range(0, 32'h1800_0000),
                     YOriginReset + $urandom_range(0, 32'h1000_0000),
                     $urandom_range(65536, 300000), $urandom_range(65536, 300000),
                     (kind == 1) ? 32'd200 : $urandom_range(1, 40),
                     ($urandom_range(0, 3) == 0) ? $urandom : EscReset,
                     $urandom, $urandom_range(0, 7) == 0);
      end
      yo = $signed(reg_vals[RegYOrigin]);
      ys = longint'(reg_vals[RegYStep][30:0]);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        col = 12'($urandom);
        row = 12'($urandom);
        case ($urandom_range(0, 7))
          0: begin
            // Aim at the rows closest to the real axis
            if (ys != 0) begin
              near_row = -yo / ys + longint'($urandom_range(0, 2)) - 1;
              if (near_row < 0) near_row = 0;
              if (near_row > 4095) near_row = 4095;
              row = near_row[11:0];
            end
          end
          1: col = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
          default: ;
        endcase
        if (gappy && $urandom_range(0, 2) == 0) pause($urandom_range(1, 12));
        send_pixel(col, row);
      end
    end

    drain();
    $display("tb: %0d pixels under %0d register settings, %0d results checked, %0d inside",
             pixels_sent, settings, checked, inside_count);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/mbe_pkg.sv
hdl/mbe_front.sv
hdl/mbe_queue.sv
hdl/mbe_core.sv
hdl/mandelbrot_escape_time_pixel.sv
test/mbe_checker.sv
test/tb.sv
